// ===== rtl/ipa_pkg.sv =====
// Shared types, codes and defaults of the index pool allocator.
`default_nettype none

package ipa_pkg;

    // Default sizes of the pool and of the free index cache.
    localparam int unsigned IPA_POOL_ENTRIES = 256;
    localparam int unsigned IPA_CACHE_DEPTH  = 16;

    // Fixed field widths.
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned ACT_W  = 9;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    // Reset value of the active entry count.
    localparam logic [ACT_W-1:0] ACTIVE_RESET = 9'd256;

    // Register index of the active entry count.
    localparam logic [0:0] REG_ACTIVE = 1'b0;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_IN_USE    = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // Input item.
    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] free_index;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        t_status          status;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/ipa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ipa_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ipa_apb.sv =====
// Configuration register file behind an APB-style port.
`default_nettype none

module ipa_apb (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ipa_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ipa_pkg::DATA_W-1:0] pwdata,
    output logic      [ipa_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output logic      [ipa_pkg::ACT_W-1:0]  o_active
);
    import ipa_pkg::*;

    logic [ACT_W-1:0] r_active;
    logic             wr_hit;

    // A write completes in the access phase; only the first word holds a register.
    assign wr_hit = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_ACTIVE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (wr_hit) begin
            r_active <= pwdata[ACT_W-1:0];
        end
    end

    // Read data and the always-ready response.
    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_ACTIVE) begin
            prdata = {{(DATA_W-ACT_W){1'b0}}, r_active};
        end
    end

    assign pready   = 1'b1;
    assign o_active = r_active;

endmodule

`default_nettype wire

// ===== rtl/ipa_seq.sv =====
// Sequencer that owns the use flag and free cache memories.
`default_nettype none

module ipa_seq #(
    parameter int unsigned POOL_ENTRIES = ipa_pkg::IPA_POOL_ENTRIES,
    parameter int unsigned CACHE_DEPTH  = ipa_pkg::IPA_CACHE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [ipa_pkg::ACT_W-1:0] i_active,
    input  wire logic                      i_in_valid,
    input  wire ipa_pkg::t_in_item         i_in_item,
    output logic                           o_in_stall,
    output logic                           o_res_valid,
    output ipa_pkg::t_out_item             o_res_item,
    input  wire logic                      i_res_take
);
    import ipa_pkg::*;

    localparam int unsigned FLAG_DEPTH = (POOL_ENTRIES < 256) ? POOL_ENTRIES : 256;
    localparam int unsigned FAW        = $clog2(FLAG_DEPTH);
    localparam int unsigned CW         = $clog2(CACHE_DEPTH + 1);
    localparam int unsigned CAW        = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_FREE  = 8'b0000_0100,
        S_ALLOC = 8'b0000_1000,
        S_POP   = 8'b0001_0000,
        S_CHK   = 8'b0010_0000,
        S_SCAN  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [FAW-1:0]    r_clr, n_clr;
    logic [IDX_W-1:0]  r_fidx, n_fidx;
    logic [IDX_W-1:0]  r_idx, n_idx;
    t_out_item         r_res, n_res;
    logic [ACT_W-1:0]  r_scan, n_scan;
    logic [CW-1:0]     r_hits, n_hits;
    logic [CW-1:0]     r_n, n_n;
    logic              r_pass, n_pass;
    logic              r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;

    logic [ACT_W-1:0]  limit;
    logic              accept;
    logic [CW-1:0]     count_dec;
    logic [CW-1:0]     target;
    logic [CW-1:0]     slot;
    logic              issue;
    logic              hit;

    // Memory ports.
    logic              flag_we;
    logic [FAW-1:0]    flag_waddr;
    logic              flag_wdata;
    logic [FAW-1:0]    flag_raddr;
    logic              flag_rdata;
    logic              cache_we;
    logic [CAW-1:0]    cache_waddr;
    logic [IDX_W-1:0]  cache_wdata;
    logic [CAW-1:0]    cache_raddr;
    logic [IDX_W-1:0]  cache_rdata;

    ipa_ram #(
        .WIDTH (1),
        .DEPTH (FLAG_DEPTH),
        .ADDR_W(FAW)
    ) u_flags (
        .i_clk  (i_clk),
        .i_we   (flag_we),
        .i_waddr(flag_waddr),
        .i_wdata(flag_wdata),
        .i_raddr(flag_raddr),
        .o_rdata(flag_rdata)
    );

    ipa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CACHE_DEPTH),
        .ADDR_W(CAW)
    ) u_cache (
        .i_clk  (i_clk),
        .i_we   (cache_we),
        .i_waddr(cache_waddr),
        .i_wdata(cache_wdata),
        .i_raddr(cache_raddr),
        .o_rdata(cache_rdata)
    );

    // Effective pool size: the active count capped by the flag memory depth.
    assign limit = (i_active > ACT_W'(FLAG_DEPTH)) ? ACT_W'(FLAG_DEPTH) : i_active;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign count_dec  = r_count - CW'(1);

    // Scan engine: the first pass counts free entries up to the cache depth, the second stacks them.
    assign target = r_pass ? r_n : CW'(CACHE_DEPTH);
    assign issue  = (r_scan < limit) && (r_hits != target);
    assign hit    = r_rd_vld && !flag_rdata && (r_hits != target);
    assign slot   = r_n - r_hits - CW'(1);

    // Next-state and memory access logic.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_clr    = r_clr;
        n_fidx   = r_fidx;
        n_idx    = r_idx;
        n_res    = r_res;
        n_scan   = r_scan;
        n_hits   = r_hits;
        n_n      = r_n;
        n_pass   = r_pass;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;

        flag_we     = 1'b0;
        flag_waddr  = r_fidx[FAW-1:0];
        flag_wdata  = 1'b0;
        flag_raddr  = r_scan[FAW-1:0];
        cache_we    = 1'b0;
        cache_waddr = r_count[CAW-1:0];
        cache_wdata = r_fidx;
        cache_raddr = count_dec[CAW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                flag_we    = 1'b1;
                flag_waddr = r_clr;
                n_clr      = r_clr + FAW'(1);
                if (r_clr == FAW'(FLAG_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_fidx = i_in_item.free_index;
                    n_res  = '{granted_index: '0, status: ST_OK};
                    if (i_in_item.command == CMD_FREE) begin
                        n_state = S_FREE;
                    end else if (r_count != '0) begin
                        n_count = count_dec;
                        n_state = S_POP;
                    end else begin
                        n_scan  = '0;
                        n_hits  = '0;
                        n_pass  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_FREE: begin
                if ({1'b0, r_fidx} >= limit) begin
                    n_res.status = ST_RANGE;
                end else begin
                    flag_we = 1'b1;
                    if (r_count != CW'(CACHE_DEPTH)) begin
                        cache_we = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
                n_state = S_RESP;
            end

            S_ALLOC: begin
                n_count = count_dec;
                n_state = S_POP;
            end

            S_POP: begin
                flag_raddr = cache_rdata[FAW-1:0];
                n_idx      = cache_rdata;
                if ({1'b0, cache_rdata} >= limit) begin
                    n_res.status = ST_RANGE;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_CHK;
                end
            end

            S_CHK: begin
                if (flag_rdata) begin
                    n_res.status = ST_IN_USE;
                end else begin
                    flag_we             = 1'b1;
                    flag_waddr          = r_idx[FAW-1:0];
                    flag_wdata          = 1'b1;
                    n_res.granted_index = r_idx;
                end
                n_state = S_RESP;
            end

            S_SCAN: begin
                if (issue) begin
                    n_scan   = r_scan + ACT_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan[IDX_W-1:0];
                end
                if (hit) begin
                    n_hits = r_hits + CW'(1);
                    if (r_pass) begin
                        cache_we    = 1'b1;
                        cache_waddr = slot[CAW-1:0];
                        cache_wdata = r_rd_idx;
                    end
                end
                // A pass ends once nothing is issued and nothing is in flight.
                if (!issue && !r_rd_vld) begin
                    if (r_pass) begin
                        n_count = r_n;
                        n_state = S_ALLOC;
                    end else if (r_hits == '0) begin
                        n_res.status = ST_EXHAUSTED;
                        n_state      = S_RESP;
                    end else begin
                        n_n    = r_hits;
                        n_pass = 1'b1;
                        n_scan = '0;
                        n_hits = '0;
                    end
                end
            end

            S_RESP: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_count  <= '0;
            r_clr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_clr    <= n_clr;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_fidx   <= n_fidx;
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_scan   <= n_scan;
        r_hits   <= n_hits;
        r_n      <= n_n;
        r_pass   <= n_pass;
        r_rd_idx <= n_rd_idx;
    end

    assign o_res_valid = (r_state == S_RESP);
    assign o_res_item  = r_res;

endmodule

`default_nettype wire

// ===== rtl/index_pool_allocator.sv =====
// Top level of the index pool allocator: configuration port, sequencer, output register.
// A free passes through S_FREE, a cached allocate through S_POP and S_CHK, then S_RESP;
// the next item is taken once S_RESP hands its result to the output register: one item at a time.
// An empty cache adds up to two scan passes, each over at most the effective pool size.
// Reset clears the flag memory one entry a cycle (256 entries by default), input stalled,
// and sets the active entry count to 256.
`default_nettype none

module index_pool_allocator #(
    parameter int unsigned POOL_ENTRIES = ipa_pkg::IPA_POOL_ENTRIES,
    parameter int unsigned CACHE_DEPTH  = ipa_pkg::IPA_CACHE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire ipa_pkg::t_in_item          i_in_item,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output ipa_pkg::t_out_item              o_out_item,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ipa_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ipa_pkg::DATA_W-1:0] pwdata,
    output logic      [ipa_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import ipa_pkg::*;

    logic [ACT_W-1:0] active;
    logic             res_valid;
    t_out_item        res_item;
    logic             res_take;
    logic             r_ovld;
    t_out_item        r_oitem;

    ipa_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_active(active)
    );

    ipa_seq #(
        .POOL_ENTRIES(POOL_ENTRIES),
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_active   (active),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_res_valid(res_valid),
        .o_res_item (res_item),
        .i_res_take (res_take)
    );

    // The output register takes a result when it is empty or being drained.
    assign res_take = !r_ovld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (res_take) begin
            r_ovld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_oitem <= res_item;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_item  = r_oitem;

endmodule

`default_nettype wire

// ===== rtl/ipa_checker.sv =====
// Port-level assertions for the index pool allocator, bound to the top level.
`default_nettype none

module ipa_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       o_in_stall,
    input  wire logic                       o_out_valid,
    input  wire logic                       i_out_stall,
    input  wire ipa_pkg::t_out_item         o_out_item
);
    import ipa_pkg::*;

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset starts the clearing pass, which holds off input transfers.
    a_reset_stall: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input not stalled during clearing pass");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Every failed request reports index zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |-> (o_out_item.granted_index == '0))
        else $error("failed request with nonzero index");

    // A transfer into the block is followed by a stall in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

endmodule

bind index_pool_allocator ipa_checker u_ipa_checker (.*);

`default_nettype wire
